// ===== rtl/fum_pkg.sv =====
// ============================================================================
// fum_pkg: shared types and constants of the float32 unary math unit
// Operation codes, binary32 constants, the sideband record and the unpacker.
// ============================================================================
package fum_pkg;

    localparam logic [3:0] OP_SQRT  = 4'd0;
    localparam logic [3:0] OP_RSQRT = 4'd1;
    localparam logic [3:0] OP_RECIP = 4'd2;
    localparam logic [3:0] OP_ABS   = 4'd3;
    localparam logic [3:0] OP_NEG   = 4'd4;
    localparam logic [3:0] OP_SIGN  = 4'd5;
    localparam logic [3:0] OP_FLOOR = 4'd6;
    localparam logic [3:0] OP_CEIL  = 4'd7;
    localparam logic [3:0] OP_TRUNC = 4'd8;
    localparam logic [3:0] OP_ROUND = 4'd9;

    localparam logic [31:0] QNAN_BIT    = 32'h0040_0000;
    localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
    localparam logic [30:0] EXP_ALL     = 31'h7F80_0000;
    localparam logic [30:0] ONE_MAG     = 31'h3F80_0000;
    localparam logic [30:0] HALF_MAG    = 31'h3F00_0000;
    localparam logic [31:0] POS_ONE     = 32'h3F80_0000;
    localparam logic [31:0] NEG_ONE     = 32'hBF80_0000;
    localparam logic [31:0] POS_ZERO    = 32'h0000_0000;

    // Number of digit-recurrence stages in each arithmetic unit
    localparam int STAGES = 28;

    // Request data that travels beside the arithmetic
    typedef struct packed {
        logic [3:0]  op;
        logic        last;
        logic [31:0] alt;
        logic [31:0] x;
    } side_t;

    // Request into the rounding packer: value = sig * 2^exp (+ sticky)
    typedef struct packed {
        logic              sign;
        logic signed [9:0] exp;
        logic [27:0]       sig;
        logic              sticky;
        logic              spec;
        logic [31:0]       spec_bits;
    } pk_t;

    typedef struct packed {
        logic [23:0]       m;
        logic signed [9:0] e;
    } unp_t;

    // Split a finite nonzero magnitude into m in [2^23, 2^24) and e
    function automatic unp_t unpack(input logic [30:0] a);
        unp_t       u;
        logic [4:0] p;
        logic [4:0] sh;
        p = '0;
        for (int i = 0; i < 23; i++) begin
            if (a[i]) begin
                p = 5'(i);
            end
        end
        sh = 5'd23 - p;
        if (a[30:23] != 8'd0) begin
            u.m = {1'b1, a[22:0]};
            u.e = $signed({2'b00, a[30:23]}) - 10'sd150;
        end else begin
            u.m = {1'b0, a[22:0]} << sh;
            u.e = -10'sd149 - $signed({5'b00000, sh});
        end
        return u;
    endfunction

endpackage

// ===== rtl/fum_in_if.sv =====
// ============================================================================
// fum_in_if: operand channel
// Valid/ready channel that carries one binary32 operand and its last flag.
// ============================================================================
interface fum_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] operand_bits;
    logic        in_last;

    modport source (output valid, operand_bits, in_last, input ready);
    modport sink   (input valid, operand_bits, in_last, output ready);
endinterface

// ===== rtl/fum_out_if.sv =====
// ============================================================================
// fum_out_if: result channel
// Valid/ready channel that carries one binary32 result and its last flag.
// ============================================================================
interface fum_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_bits;
    logic        out_last;

    modport source (output valid, result_bits, out_last, input ready);
    modport sink   (input valid, result_bits, out_last, output ready);
endinterface

// ===== rtl/fum_pack.sv =====
// ============================================================================
// fum_pack: two-stage round-to-nearest-even packer
// Normalizes, denormalizes into the subnormal range, rounds and overflows.
// ============================================================================
module fum_pack (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  fum_pkg::pk_t   req,
    input  fum_pkg::side_t side_in,
    output logic           out_valid,
    output logic [31:0]    bits,
    output fum_pkg::side_t side_out
);
    import fum_pkg::*;

    // Stage A registers
    logic        a_valid_reg;
    logic        a_sign_reg;
    logic [7:0]  a_bexp_reg;
    logic [4:0]  a_sh_reg;
    logic [26:0] a_sig_reg;
    logic        a_sticky_reg;
    logic        a_ovf_reg;
    logic        a_spec_reg;
    logic [31:0] a_spec_bits_reg;
    side_t       a_side_reg;

    logic [7:0]  a_bexp_next;
    logic [4:0]  a_sh_next;
    logic [26:0] a_sig_next;
    logic        a_sticky_next;
    logic        a_ovf_next;

    // Stage B registers
    logic        b_valid_reg;
    logic [31:0] b_bits_reg;
    side_t       b_side_reg;
    logic [31:0] b_bits_next;

    // Normalize to 27 bits and work out the biased exponent
    always_comb begin
        logic signed [10:0] e1;
        logic signed [10:0] bx;
        logic signed [10:0] shv;
        logic [27:0]        s;
        logic               st;
        s  = req.sig;
        st = req.sticky;
        e1 = 11'(req.exp);
        if (s[27]) begin
            st = st | s[0];
            s  = s >> 1;
            e1 = e1 + 11'sd1;
        end
        bx            = e1 + 11'sd153;
        shv           = 11'sd1 - bx;
        a_ovf_next    = (bx >= 11'sd255);
        a_sig_next    = s[26:0];
        a_sticky_next = st;
        if (bx <= 11'sd0) begin
            a_bexp_next = 8'd0;
            a_sh_next   = (shv > 11'sd31) ? 5'd31 : shv[4:0];
        end else begin
            a_bexp_next = bx[7:0];
            a_sh_next   = 5'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            a_sign_reg      <= req.sign;
            a_bexp_reg      <= a_bexp_next;
            a_sh_reg        <= a_sh_next;
            a_sig_reg       <= a_sig_next;
            a_sticky_reg    <= a_sticky_next;
            a_ovf_reg       <= a_ovf_next;
            a_spec_reg      <= req.spec;
            a_spec_bits_reg <= req.spec_bits;
            a_side_reg      <= side_in;
        end
    end

    // Shift into the subnormal range, round and assemble
    always_comb begin
        logic [31:0] sv;
        logic [31:0] shifted;
        logic [31:0] lost;
        logic        st;
        logic [23:0] keep;
        logic [2:0]  low;
        logic        up;
        logic [24:0] kr;
        sv      = {5'b00000, a_sig_reg};
        shifted = sv >> a_sh_reg;
        lost    = sv & ~(32'hFFFF_FFFF << a_sh_reg);
        st      = a_sticky_reg | (lost != 32'd0);
        keep    = shifted[26:3];
        low     = shifted[2:0];
        up      = (low > 3'd4) || ((low == 3'd4) && (st || keep[0]));
        kr      = {1'b0, keep} + {24'd0, up};
        if (a_spec_reg) begin
            b_bits_next = a_spec_bits_reg;
        end else if (a_ovf_reg) begin
            b_bits_next = {a_sign_reg, EXP_ALL};
        end else if (a_bexp_reg == 8'd0) begin
            b_bits_next = {a_sign_reg, 6'd0, kr};
        end else begin
            b_bits_next = {a_sign_reg, {a_bexp_reg - 8'd1, 23'd0} + {6'd0, kr}};
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            b_bits_reg <= b_bits_next;
            b_side_reg <= a_side_reg;
        end
    end

    assign out_valid = b_valid_reg;
    assign bits      = b_bits_reg;
    assign side_out  = b_side_reg;

endmodule

// ===== rtl/fum_sqrt.sv =====
// ============================================================================
// fum_sqrt: pipelined binary32 square root
// Unpack stage, one root bit per stage over 28 stages, then the packer.
// ============================================================================
module fum_sqrt (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [31:0]    x,
    input  fum_pkg::side_t side_in,
    output logic           out_valid,
    output logic [31:0]    y,
    output fum_pkg::side_t side_out
);
    import fum_pkg::*;

    logic              v_reg     [0:STAGES];
    logic [31:0]       rem_reg   [0:STAGES];
    logic [27:0]       root_reg  [0:STAGES];
    logic [55:0]       rad_reg   [0:STAGES];
    logic signed [9:0] exp_reg   [0:STAGES];
    logic              spec_reg  [0:STAGES];
    logic [31:0]       sbits_reg [0:STAGES];
    side_t             side_reg  [0:STAGES];

    logic [55:0]       rad_next;
    logic signed [9:0] exp_next;
    logic              spec_next;
    logic [31:0]       sbits_next;
    pk_t               pk_req;

    // Sort out special operands and set up the radicand
    always_comb begin
        unp_t              u;
        logic signed [9:0] ed;
        logic              nan;
        u   = unpack(x[30:0]);
        nan = (x[30:0] > EXP_ALL);
        if (u.e[0]) begin
            rad_next = {3'b000, u.m, 29'd0};
            ed       = u.e - 10'sd29;
        end else begin
            rad_next = {2'b00, u.m, 30'd0};
            ed       = u.e - 10'sd30;
        end
        exp_next = ed >>> 1;
        if (nan) begin
            spec_next  = 1'b1;
            sbits_next = x | QNAN_BIT;
        end else if (x[30:0] == 31'd0) begin
            spec_next  = 1'b1;
            sbits_next = x;
        end else if (x[31]) begin
            spec_next  = 1'b1;
            sbits_next = DEFAULT_NAN;
        end else if (x[30:0] == EXP_ALL) begin
            spec_next  = 1'b1;
            sbits_next = x;
        end else begin
            spec_next  = 1'b0;
            sbits_next = x;
        end
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int k = 0; k <= STAGES; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int k = 0; k < STAGES; k++) begin
                v_reg[k+1] <= v_reg[k];
            end
        end
    end

    // Retire one root bit per stage
    always_ff @(posedge clk) begin
        if (en) begin
            rem_reg[0]   <= 32'd0;
            root_reg[0]  <= 28'd0;
            rad_reg[0]   <= rad_next;
            exp_reg[0]   <= exp_next;
            spec_reg[0]  <= spec_next;
            sbits_reg[0] <= sbits_next;
            side_reg[0]  <= side_in;
            for (int k = 0; k < STAGES; k++) begin
                logic [31:0] rn;
                logic [31:0] trial;
                logic        ge;
                rn    = {rem_reg[k][29:0], rad_reg[k][55:54]};
                trial = {2'b00, root_reg[k], 2'b01};
                ge    = (rn >= trial);
                rem_reg[k+1]   <= ge ? (rn - trial) : rn;
                root_reg[k+1]  <= {root_reg[k][26:0], ge};
                rad_reg[k+1]   <= {rad_reg[k][53:0], 2'b00};
                exp_reg[k+1]   <= exp_reg[k];
                spec_reg[k+1]  <= spec_reg[k];
                sbits_reg[k+1] <= sbits_reg[k];
                side_reg[k+1]  <= side_reg[k];
            end
        end
    end

    always_comb begin
        pk_req.sign      = 1'b0;
        pk_req.exp       = exp_reg[STAGES];
        pk_req.sig       = root_reg[STAGES];
        pk_req.sticky    = (rem_reg[STAGES] != 32'd0);
        pk_req.spec      = spec_reg[STAGES];
        pk_req.spec_bits = sbits_reg[STAGES];
    end

    fum_pack u_pack (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v_reg[STAGES]),
        .req      (pk_req),
        .side_in  (side_reg[STAGES]),
        .out_valid(out_valid),
        .bits     (y),
        .side_out (side_out)
    );

endmodule

// ===== rtl/fum_recip.sv =====
// ============================================================================
// fum_recip: pipelined binary32 reciprocal
// Unpack stage, one quotient bit per stage over 28 stages, then the packer.
// ============================================================================
module fum_recip (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [31:0]    x,
    input  fum_pkg::side_t side_in,
    output logic           out_valid,
    output logic [31:0]    y,
    output fum_pkg::side_t side_out
);
    import fum_pkg::*;

    logic              v_reg     [0:STAGES];
    logic [24:0]       rem_reg   [0:STAGES];
    logic [27:0]       q_reg     [0:STAGES];
    logic [23:0]       m_reg     [0:STAGES];
    logic              sign_reg  [0:STAGES];
    logic signed [9:0] exp_reg   [0:STAGES];
    logic              spec_reg  [0:STAGES];
    logic [31:0]       sbits_reg [0:STAGES];
    side_t             side_reg  [0:STAGES];

    logic [23:0]       m_next;
    logic signed [9:0] exp_next;
    logic              spec_next;
    logic [31:0]       sbits_next;
    pk_t               pk_req;

    // Sort out special operands and unpack the divisor
    always_comb begin
        unp_t u;
        u        = unpack(x[30:0]);
        m_next   = u.m;
        exp_next = -u.e - 10'sd50;
        if (x[30:0] > EXP_ALL) begin
            spec_next  = 1'b1;
            sbits_next = x | QNAN_BIT;
        end else if (x[30:0] == 31'd0) begin
            spec_next  = 1'b1;
            sbits_next = {x[31], EXP_ALL};
        end else if (x[30:0] == EXP_ALL) begin
            spec_next  = 1'b1;
            sbits_next = {x[31], 31'd0};
        end else begin
            spec_next  = 1'b0;
            sbits_next = x;
        end
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int k = 0; k <= STAGES; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int k = 0; k < STAGES; k++) begin
                v_reg[k+1] <= v_reg[k];
            end
        end
    end

    // Retire one quotient bit per stage of 2^50 / m
    always_ff @(posedge clk) begin
        if (en) begin
            rem_reg[0]   <= 25'h080_0000;
            q_reg[0]     <= 28'd0;
            m_reg[0]     <= m_next;
            sign_reg[0]  <= x[31];
            exp_reg[0]   <= exp_next;
            spec_reg[0]  <= spec_next;
            sbits_reg[0] <= sbits_next;
            side_reg[0]  <= side_in;
            for (int k = 0; k < STAGES; k++) begin
                logic        ge;
                logic [24:0] d;
                ge = (rem_reg[k] >= {1'b0, m_reg[k]});
                d  = ge ? (rem_reg[k] - {1'b0, m_reg[k]}) : rem_reg[k];
                rem_reg[k+1]   <= {d[23:0], 1'b0};
                q_reg[k+1]     <= {q_reg[k][26:0], ge};
                m_reg[k+1]     <= m_reg[k];
                sign_reg[k+1]  <= sign_reg[k];
                exp_reg[k+1]   <= exp_reg[k];
                spec_reg[k+1]  <= spec_reg[k];
                sbits_reg[k+1] <= sbits_reg[k];
                side_reg[k+1]  <= side_reg[k];
            end
        end
    end

    always_comb begin
        pk_req.sign      = sign_reg[STAGES];
        pk_req.exp       = exp_reg[STAGES];
        pk_req.sig       = q_reg[STAGES];
        pk_req.sticky    = (rem_reg[STAGES] != 25'd0);
        pk_req.spec      = spec_reg[STAGES];
        pk_req.spec_bits = sbits_reg[STAGES];
    end

    fum_pack u_pack (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v_reg[STAGES]),
        .req      (pk_req),
        .side_in  (side_reg[STAGES]),
        .out_valid(out_valid),
        .bits     (y),
        .side_out (side_out)
    );

endmodule

// ===== rtl/float32_unary_math_unit.sv =====
// ============================================================================
// float32_unary_math_unit: elementwise binary32 unary math pipeline
// Square root, reciprocal square root, reciprocal and bitwise/rounding ops.
// ============================================================================
// Usage:
//   cfg_we/cfg_data write the 4-bit operation code; write it only while the
//   pipeline is empty. Operand requests enter on in_ch and one result per
//   request leaves on out_ch, in order, with in_last copied to out_last.
//   Throughput: one request per cycle, every operation code, while not stalled.
//   Path: every request passes the square-root section (unpack, 28 root-bit
//   stages, 2 pack stages), then the reciprocal section (same depth), then
//   the output register, whatever the operation code.
//   Every request crosses both sections, so rsqrt costs no extra time.
//   Stall: the whole pipeline advances on one enable, which is high while
//   the output register is empty or being taken; in_ch.ready follows it, so
//   a stalled receiver holds every stage and nothing is lost or repeated.
//   Reset: all valid bits clear and the operation code returns to sqrt.
// ============================================================================
module float32_unary_math_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [3:0] cfg_data,
    fum_in_if.sink     in_ch,
    fum_out_if.source  out_ch
);
    import fum_pkg::*;

    logic [3:0]  op_reg;
    logic        en;
    side_t       side_first;
    logic [31:0] alt_first;

    logic        sq_valid;
    logic [31:0] sq_y;
    side_t       sq_side;
    logic [31:0] rc_x;
    side_t       rc_side_in;

    logic        rc_valid;
    logic [31:0] rc_y;
    side_t       rc_side;

    logic        out_valid_reg;
    logic [31:0] out_bits_reg;
    logic        out_last_reg;
    logic [3:0]  out_op_reg;
    logic [31:0] out_bits_next;

    // floor, ceil, trunc and round-half-to-even on raw bits
    function automatic logic [31:0] round_op(input logic [31:0] x, input logic [3:0] op);
        logic [30:0] a;
        logic        sgn;
        logic [7:0]  f;
        logic [4:0]  fb;
        logic [31:0] unit;
        logic [31:0] mask;
        logic [31:0] frac;
        logic [31:0] t;
        logic        up;
        logic [31:0] res;
        a    = x[30:0];
        sgn  = x[31];
        f    = x[30:23];
        fb   = 5'(8'd150 - f);
        unit = 32'd1 << fb;
        mask = unit - 32'd1;
        frac = {1'b0, a} & mask;
        t    = x & ~mask;
        case (op)
            OP_FLOOR: up = sgn;
            OP_CEIL:  up = !sgn;
            default:  up = 1'b0;
        endcase
        if (a > EXP_ALL) begin
            res = x | QNAN_BIT;
        end else if ((a == 31'd0) || (f >= 8'd150)) begin
            res = x;
        end else if (f < 8'd127) begin
            if (op == OP_ROUND) begin
                up = (a > HALF_MAG);
            end
            res = up ? {sgn, ONE_MAG} : {sgn, 31'd0};
        end else if (frac == 32'd0) begin
            res = x;
        end else begin
            if (op == OP_ROUND) begin
                up = (frac > (unit >> 1)) || ((frac == (unit >> 1)) && ((t & unit) != 32'd0));
            end
            res = up ? (t + unit) : t;
        end
        return res;
    endfunction

    // Hold the operation code
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            op_reg <= OP_SQRT;
        end else if (cfg_we) begin
            op_reg <= cfg_data;
        end
    end

    assign en          = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = en;

    // Work out the bitwise and rounding operations at entry
    always_comb begin
        logic [31:0] x;
        x = in_ch.operand_bits;
        case (op_reg)
            OP_ABS:   alt_first = {1'b0, x[30:0]};
            OP_NEG:   alt_first = {!x[31], x[30:0]};
            OP_SIGN:
                if ((x[30:0] > EXP_ALL) || (x[30:0] == 31'd0)) begin
                    alt_first = POS_ZERO;
                end else begin
                    alt_first = x[31] ? NEG_ONE : POS_ONE;
                end
            OP_FLOOR: alt_first = round_op(x, OP_FLOOR);
            OP_CEIL:  alt_first = round_op(x, OP_CEIL);
            OP_TRUNC: alt_first = round_op(x, OP_TRUNC);
            OP_ROUND: alt_first = round_op(x, OP_ROUND);
            default:  alt_first = x;
        endcase
        side_first.op   = op_reg;
        side_first.last = in_ch.in_last;
        side_first.alt  = alt_first;
        side_first.x    = x;
    end

    fum_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_ch.valid),
        .x        (in_ch.operand_bits),
        .side_in  (side_first),
        .out_valid(sq_valid),
        .y        (sq_y),
        .side_out (sq_side)
    );

    // Route the root into the reciprocal or keep it as the result
    always_comb begin
        rc_side_in = sq_side;
        rc_x       = (sq_side.op == OP_RSQRT) ? sq_y : sq_side.x;
        if (sq_side.op == OP_SQRT) begin
            rc_side_in.alt = sq_y;
        end
    end

    fum_recip u_recip (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (sq_valid),
        .x        (rc_x),
        .side_in  (rc_side_in),
        .out_valid(rc_valid),
        .y        (rc_y),
        .side_out (rc_side)
    );

    assign out_bits_next = ((rc_side.op == OP_RECIP) || (rc_side.op == OP_RSQRT)) ?
                           rc_y : rc_side.alt;

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= rc_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            out_bits_reg <= out_bits_next;
            out_last_reg <= rc_side.last;
            out_op_reg   <= rc_side.op;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.result_bits = out_bits_reg;
    assign out_ch.out_last    = out_last_reg;

    // The input may only be taken when the output register can move
    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready == (!out_ch.valid || out_ch.ready))
        else $error("input ready does not follow output stall");

    // An absolute value never leaves with the sign set
    a_abs_sign_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_op_reg == OP_ABS)) |-> !out_bits_reg[31])
        else $error("abs result carries a sign");

    // A sign result is one of the three fixed values
    a_sign_values: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_op_reg == OP_SIGN)) |->
        ((out_bits_reg == POS_ONE) || (out_bits_reg == NEG_ONE) ||
         (out_bits_reg == POS_ZERO)))
        else $error("sign result out of range");

endmodule

// ===== tb/float32_unary_math_unit_tb.sv =====
// ============================================================================
// float32_unary_math_unit_tb: self-checking bench of the binary32 unary unit
// Drives operand requests under random idling on both channels, predicts each
// result with a bit-exact integer model of every operation code, and checks
// results in order against the predictions.
// ============================================================================
module float32_unary_math_unit_tb;
    import fum_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] OP_PASS_LO = 4'd10;
    localparam logic [3:0] OP_PASS_HI = 4'd15;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         DRAIN_CYCLES = 80;
    localparam int         ITEMS_PER_OP = 25;

    typedef struct {
        logic [31:0] bits;
        logic        last;
    } fp_item_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [3:0] cfg_data;

    fum_in_if  in_ch ();
    fum_out_if out_ch ();

    float32_unary_math_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    fp_item_t   operand_q[$];
    fp_item_t   result_q[$];
    logic [3:0] cur_op;
    int         tx_idle_pct;
    int         rx_idle_pct;
    bit         tx_hold;
    int         err_count;
    int         sent_count;
    int         checked_count;
    int         cycle_count;

    // ------------------------------------------------------------------
    // Bit-exact arithmetic
    // ------------------------------------------------------------------
    function automatic bit fp_is_nan(logic [31:0] b);
        return b[30:0] > EXP_ALL;
    endfunction

    // Round sig * 2^e (+ sticky) to binary32
    function automatic logic [31:0] fp_round_pack(logic sign, int e, logic [63:0] sig,
                                                  bit sticky);
        int          b;
        int          sh;
        logic [31:0] keep;
        logic [2:0]  low;
        while (sig >= (64'd1 << 27))
        begin
            sticky = sticky || sig[0];
            sig = sig >> 1;
            e = e + 1;
        end
        while (sig < (64'd1 << 26))
        begin
            sig = sig << 1;
            e = e - 1;
        end
        b = e + 26 + 127;
        if (b >= 255)
            return {sign, EXP_ALL};
        if (b <= 0)
        begin
            sh = 1 - b;
            if (sh > 30)
            begin
                sticky = 1'b1;
                sig = '0;
            end
            else
            begin
                sticky = sticky || ((sig & ((64'd1 << sh) - 64'd1)) != 0);
                sig = sig >> sh;
            end
            b = 0;
        end
        keep = sig[34:3];
        low = sig[2:0];
        if (low > 3'd4 || (low == 3'd4 && (sticky || keep[0])))
            keep = keep + 32'd1;
        if (b == 0)
            return {sign, 31'd0} | keep;
        return {sign, 31'd0} | ((32'(b - 1) << 23) + keep);
    endfunction

    // Split a finite nonzero magnitude into mantissa and exponent
    function automatic void fp_split(logic [30:0] a, output logic [31:0] m, output int e);
        if (a[30:23] != 8'd0)
        begin
            m = {9'd1, a[22:0]};
            e = int'(a[30:23]) - 150;
        end
        else
        begin
            m = {9'd0, a[22:0]};
            e = -149;
            while (m < 32'h0080_0000)
            begin
                m = m << 1;
                e = e - 1;
            end
        end
    endfunction

    function automatic logic [31:0] fp_sqrt(logic [31:0] x);
        logic [31:0] m;
        int          e;
        int          s;
        logic [63:0] root;
        logic [63:0] probe;
        logic [63:0] rem;
        if (fp_is_nan(x))
            return x | QNAN_BIT;
        if (x[30:0] == 0)
            return x;
        if (x[31])
            return DEFAULT_NAN;
        if (x[30:0] == EXP_ALL)
            return x;
        fp_split(x[30:0], m, e);
        s = (e % 2 == 0) ? 30 : 29;
        rem = 64'(m) << s;
        root = '0;
        probe = 64'd1 << 54;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (rem >= root + probe)
            begin
                rem = rem - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root = root >> 1;
            probe = probe >> 2;
        end
        return fp_round_pack(1'b0, (e - s) / 2, root, rem != 0);
    endfunction

    function automatic logic [31:0] fp_recip(logic [31:0] x);
        logic [31:0] m;
        int          e;
        logic [63:0] num;
        if (fp_is_nan(x))
            return x | QNAN_BIT;
        if (x[30:0] == 0)
            return {x[31], EXP_ALL};
        if (x[30:0] == EXP_ALL)
            return {x[31], 31'd0};
        fp_split(x[30:0], m, e);
        num = 64'd1 << 62;
        return fp_round_pack(x[31], -e - 62, num / 64'(m), (num % 64'(m)) != 0);
    endfunction

    // Integer rounding in the mode given by the operation code
    function automatic logic [31:0] fp_to_integral(logic [31:0] x, logic [3:0] op);
        logic        sign;
        logic [7:0]  f;
        logic [31:0] unit;
        logic [31:0] mask;
        logic [31:0] frac;
        logic [31:0] t;
        bit          up;
        sign = x[31];
        f = x[30:23];
        if (fp_is_nan(x))
            return x | QNAN_BIT;
        if (x[30:0] == 0 || f >= 8'd150)
            return x;
        if (f < 8'd127)
        begin
            case (op)
                OP_FLOOR: up = sign;
                OP_CEIL:  up = !sign;
                OP_TRUNC: up = 1'b0;
                default:  up = x[30:0] > HALF_MAG;
            endcase
            return up ? {sign, ONE_MAG} : {sign, 31'd0};
        end
        unit = 32'd1 << (150 - int'(f));
        mask = unit - 32'd1;
        frac = x & mask;
        t = x & ~mask;
        if (frac == 0)
            return x;
        case (op)
            OP_FLOOR: up = sign;
            OP_CEIL:  up = !sign;
            OP_TRUNC: up = 1'b0;
            default:  up = frac > (unit >> 1) || (frac == (unit >> 1) && (t & unit) != 0);
        endcase
        return up ? t + unit : t;
    endfunction

    function automatic logic [31:0] unary_result(logic [31:0] x, logic [3:0] op);
        case (op)
            OP_SQRT:  return fp_sqrt(x);
            OP_RSQRT: return fp_recip(fp_sqrt(x));
            OP_RECIP: return fp_recip(x);
            OP_ABS:   return {1'b0, x[30:0]};
            OP_NEG:   return {~x[31], x[30:0]};
            OP_SIGN:
            begin
                if (fp_is_nan(x) || x[30:0] == 0)
                    return POS_ZERO;
                return x[31] ? NEG_ONE : POS_ONE;
            end
            OP_FLOOR, OP_CEIL, OP_TRUNC, OP_ROUND: return fp_to_integral(x, op);
            default:  return x;
        endcase
    endfunction

    // Random operand biased toward special classes and near-integer values
    function automatic logic [31:0] pick_operand();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0: r[30:23] = 8'd0;
            1: r[30:23] = 8'hFF;
            2: r[30:0] = ($urandom_range(1) != 0) ? 31'd0 : EXP_ALL;
            3, 4, 5: r[30:23] = 8'($urandom_range(151, 120));
            6: r[22:0] = 23'(r[22:0] & ~((23'd1 << $urandom_range(22)) - 23'd1));
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Driver: take requests from the operand queue, record predictions
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.operand_bits <= '0;
            in_ch.in_last <= 1'b0;
        end
        else
        begin
            // predict for the request accepted at this edge
            if (in_ch.valid && in_ch.ready)
            begin
                result_q.push_back('{unary_result(in_ch.operand_bits, cur_op), in_ch.in_last});
                sent_count++;
            end
            // advance to the next request once the current one is gone
            if (!in_ch.valid || in_ch.ready)
            begin
                if (operand_q.size() != 0 && !tx_hold && $urandom_range(99) >= tx_idle_pct)
                begin
                    fp_item_t nxt;
                    nxt = operand_q.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.operand_bits <= nxt.bits;
                    in_ch.in_last <= nxt.last;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted result with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (result_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h last %b", $time,
                             out_ch.result_bits, out_ch.out_last);
                    err_count++;
                end
                else
                begin
                    fp_item_t want;
                    want = result_q.pop_front();
                    checked_count++;
                    if (want.bits !== out_ch.result_bits)
                    begin
                        $display("%0t: result_bits expected %h actual %h (op %0d)", $time,
                                 want.bits, out_ch.result_bits, cur_op);
                        err_count++;
                    end
                    if (want.last !== out_ch.out_last)
                    begin
                        $display("%0t: out_last expected %b actual %b", $time,
                                 want.last, out_ch.out_last);
                        err_count++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, result_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    task automatic wait_idle();
        while (operand_q.size() != 0 || in_ch.valid || result_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_operation(logic [3:0] op);
        wait_idle();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= op;
        cur_op = op;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_operand(logic [31:0] bits, logic last);
        operand_q.push_back('{bits, last});
    endtask

    initial
    begin
        logic [3:0] op;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        cur_op = OP_SQRT;
        tx_idle_pct = 28;
        rx_idle_pct = 81;
        tx_hold = 1'b0;
        err_count = 0;
        sent_count = 0;
        checked_count = 0;
        cycle_count = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: square root specials
        set_operation(OP_SQRT);
        queue_operand(32'h0000_0000, 1'b0);
        queue_operand(32'h8000_0000, 1'b1);
        queue_operand(32'h7F80_0000, 1'b0);
        queue_operand(32'hFF80_0000, 1'b0);
        queue_operand(32'hBF80_0000, 1'b0);
        queue_operand(32'h7F80_0001, 1'b1);
        queue_operand(32'h0000_0001, 1'b0);
        queue_operand(32'h7F7F_FFFF, 1'b0);
        queue_operand(32'h4080_0000, 1'b1);
        queue_operand(32'hFFFF_FFFF, 1'b0);

        // directed: reciprocal overflow and underflow
        set_operation(OP_RECIP);
        queue_operand(32'h0000_0000, 1'b1);
        queue_operand(32'h8000_0000, 1'b0);
        queue_operand(32'hFF80_0000, 1'b0);
        queue_operand(32'h0000_0001, 1'b1);
        queue_operand(32'h7F7F_FFFF, 1'b0);
        queue_operand(32'h0020_0000, 1'b0);
        queue_operand(32'hFFC0_0001, 1'b1);
        queue_operand(32'h3F80_0000, 1'b0);

        // directed: round half to even around small values and ties
        set_operation(OP_ROUND);
        queue_operand(32'h3F00_0000, 1'b0);
        queue_operand(32'h3F00_0001, 1'b0);
        queue_operand(32'h3FC0_0000, 1'b1);
        queue_operand(32'hC020_0000, 1'b0);
        queue_operand(32'h4B00_0000, 1'b0);
        queue_operand(32'hBE80_0000, 1'b1);
        queue_operand(32'h7FA0_0000, 1'b0);

        // random: one phase per operation code, idling pattern by phase
        for (int p = 0; p < 16; p++)
        begin
            op = 4'(p);
            set_operation(op);
            if (p < 6)
            begin
                tx_idle_pct = 28;
                rx_idle_pct = 81;
            end
            else if (p < 11)
            begin
                tx_idle_pct = 81;
                rx_idle_pct = 28;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (int i = 0; i < ITEMS_PER_OP; i++)
                queue_operand(pick_operand(), 1'($urandom_range(1)));
            // hold the sender mid-phase until every result has drained
            if (p == 3)
            begin
                while (operand_q.size() > ITEMS_PER_OP / 2)
                    @(posedge clk);
                tx_hold = 1'b1;
                while (in_ch.valid || result_q.size() != 0)
                    @(posedge clk);
                tx_hold = 1'b0;
            end
        end
        // return to the reset operation with a final short burst
        set_operation(OP_SQRT);
        for (int i = 0; i < 10; i++)
            queue_operand(pick_operand(), 1'($urandom_range(1)));

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d operand requests over all 16 operation codes (%0d..%0d pass).",
                 sent_count, OP_PASS_LO, OP_PASS_HI);
        $display("Checked %0d results, %0d mismatches.", checked_count, err_count);
        if (err_count == 0 && result_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
